// ===== sv/sic_pkg.sv =====
`default_nettype none
// ============================================================================
// sic_pkg: shared definitions for the spiral index to coordinate block
// Widths, reset values and the control word that travels down the search
// chain.
// ============================================================================
package sic_pkg;

    // Spiral position width, fixed by the input word format
    localparam int INDEX_WIDTH = 32;

    // Default coordinate width (row, column and grid size)
    localparam int COORD_WIDTH_DEF = 16;

    // Grid size after reset
    localparam int GRID_SIZE_RESET = 1;

    // Control carried alongside each word through the chain
    typedef struct packed {
        logic valid;
        logic in_range;
    } ctl_t;

    // Width that holds both 4*x*(n-x) and a spiral position
    function automatic int prod_width(input int coord_width);
        int w;
        w = 2 * coord_width + 1;
        if (w < INDEX_WIDTH) begin
            w = INDEX_WIDTH;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== sv/sic_in_if.sv =====
`default_nettype none
// ============================================================================
// sic_in_if: input word channel
// Carries one spiral position per word under a valid/ready handshake.
// ============================================================================
interface sic_in_if;

    logic                           valid;
    logic                           ready;
    logic [sic_pkg::INDEX_WIDTH-1:0] index;

    modport source (output valid, output index, input ready);
    modport sink   (input valid, input index, output ready);

endinterface
`default_nettype wire

// ===== sv/sic_out_if.sv =====
`default_nettype none
// ============================================================================
// sic_out_if: result word channel
// Carries one row/column pair and its range flag per word.
// ============================================================================
interface sic_out_if #(
    parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
);

    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] row;
    logic [COORD_WIDTH-1:0] column;
    logic                   in_range;

    modport source (output valid, output row, output column, output in_range, input ready);
    modport sink   (input valid, input row, input column, input in_range, output ready);

endinterface
`default_nettype wire

// ===== sv/sic_search_cell.sv =====
`default_nettype none
// ============================================================================
// sic_search_cell: one bit of the shell count search
// Tries setting its bit of the running shell count and keeps it when the
// candidate stays within half the grid and 4*x*(n-x) is below the position.
// ============================================================================
module sic_search_cell #(
    parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF,
    parameter int BIT_POS     = 0
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire sic_pkg::ctl_t                   ctl_in,
    input  wire logic [COORD_WIDTH-1:0]          n_in,
    input  wire logic [sic_pkg::INDEX_WIDTH-1:0] index_in,
    input  wire logic [COORD_WIDTH-2:0]          x_in,
    output sic_pkg::ctl_t                        ctl_out,
    output logic [COORD_WIDTH-1:0]               n_out,
    output logic [sic_pkg::INDEX_WIDTH-1:0]      index_out,
    output logic [COORD_WIDTH-2:0]               x_out
);
    import sic_pkg::*;

    localparam int XW = COORD_WIDTH - 1;
    localparam int PW = prod_width(COORD_WIDTH);
    localparam logic [XW-1:0] TRY_BIT = XW'(1) << BIT_POS;

    logic [XW-1:0]            cand;
    logic [COORD_WIDTH-1:0]   half;
    logic [COORD_WIDTH-1:0]   diff;
    logic                     fits;
    logic [2*COORD_WIDTH-2:0] prod;
    logic [PW-1:0]            ring;
    logic                     take;
    logic [XW-1:0]            x_next;

    ctl_t                     ctl_reg;
    logic [COORD_WIDTH-1:0]   n_reg;
    logic [INDEX_WIDTH-1:0]   index_reg;
    logic [XW-1:0]            x_reg;

    // Trial value and cells in the outer shells it would cover
    assign cand = x_in | TRY_BIT;
    assign half = n_in >> 1;
    assign fits = ({1'b0, cand} <= half);
    assign diff = n_in - {1'b0, cand};
    assign prod = {{COORD_WIDTH{1'b0}}, cand} * {{XW{1'b0}}, diff};
    assign ring = PW'({prod, 2'b00});

    // Keep the bit when those shells still end before the position
    assign take   = ctl_in.in_range && fits && (ring < PW'(index_in));
    assign x_next = take ? cand : x_in;

    // Hand the word to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n_reg     <= n_in;
            index_reg <= index_in;
            x_reg     <= x_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign n_out     = n_reg;
    assign index_out = index_reg;
    assign x_out     = x_reg;

endmodule
`default_nettype wire

// ===== sv/sic_place.sv =====
`default_nettype none
// ============================================================================
// sic_place: place the position on its shell
// Removes the cells of the outer shells, then walks the four sides of the
// current shell to get row and column. Holds the result word.
// ============================================================================
module sic_place #(
    parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire sic_pkg::ctl_t                   ctl_in,
    input  wire logic [COORD_WIDTH-1:0]          n_in,
    input  wire logic [sic_pkg::INDEX_WIDTH-1:0] index_in,
    input  wire logic [COORD_WIDTH-2:0]          x_in,
    output logic                                 valid,
    output logic [COORD_WIDTH-1:0]               row,
    output logic [COORD_WIDTH-1:0]               column,
    output logic                                 in_range
);
    import sic_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int XW = COORD_WIDTH - 1;
    localparam int PW = prod_width(COORD_WIDTH);

    // Stage A: shell cell count
    ctl_t                   ctl_a_reg;
    logic [W-1:0]           n_a_reg;
    logic [INDEX_WIDTH-1:0] index_a_reg;
    logic [XW-1:0]          x_a_reg;
    logic [PW-1:0]          ring_a_reg;
    logic [W-1:0]           diff;
    logic [2*W-2:0]         prod;
    logic [PW-1:0]          ring_next;

    // Stage B: side walk and result word
    logic [W-1:0]  shell;
    logic [W-1:0]  lim;
    logic [W-1:0]  side;
    logic [PW-1:0] t1;
    logic [PW-1:0] t2;
    logic [PW-1:0] t3;
    logic [PW-1:0] r;
    logic [PW-1:0] d1;
    logic [PW-1:0] d2;
    logic [PW-1:0] d3;
    logic [PW-1:0] d4;
    logic [W-1:0]  row_next;
    logic [W-1:0]  column_next;

    logic          out_valid_reg;
    logic          in_range_reg;
    logic [W-1:0]  row_reg;
    logic [W-1:0]  column_reg;
    logic [W-1:0]  n_b_reg;
    logic [W-1:0]  shell_b_reg;
    logic [W-1:0]  corner_b_reg;

    // Cells in the x outer shells: 4*x*(n-x)
    assign diff      = n_in - {1'b0, x_in};
    assign prod      = {{W{1'b0}}, x_in} * {{XW{1'b0}}, diff};
    assign ring_next = PW'({prod, 2'b00});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
        end
        else if (advance)
        begin
            ctl_a_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n_a_reg     <= n_in;
            index_a_reg <= index_in;
            x_a_reg     <= x_in;
            ring_a_reg  <= ring_next;
        end
    end

    // Shell geometry and side boundaries
    assign shell = {1'b0, x_a_reg} + W'(1);
    assign lim   = n_a_reg - {x_a_reg, 1'b0};
    assign side  = lim - W'(1);
    assign t1    = PW'(lim);
    assign t2    = t1 + PW'(side);
    assign t3    = t2 + PW'(side);
    assign r     = PW'(index_a_reg) - ring_a_reg;
    assign d1    = r - PW'(1);
    assign d2    = r - t1;
    assign d3    = r - t2;
    assign d4    = r - t3;

    // Walk top, right, bottom, left
    always_comb
    begin
        row_next    = '0;
        column_next = '0;
        if (ctl_a_reg.in_range)
        begin
            priority if (r <= t1)
            begin
                row_next    = shell;
                column_next = shell + d1[W-1:0];
            end
            else if (r <= t2)
            begin
                row_next    = shell + d2[W-1:0];
                column_next = shell + side;
            end
            else if (r <= t3)
            begin
                row_next    = shell + side;
                column_next = shell + side - d3[W-1:0];
            end
            else
            begin
                row_next    = shell + side - d4[W-1:0];
                column_next = shell;
            end
        end
    end

    // Hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= ctl_a_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_range_reg <= ctl_a_reg.in_range;
            row_reg      <= row_next;
            column_reg   <= column_next;
            n_b_reg      <= n_a_reg;
            shell_b_reg  <= shell;
            corner_b_reg <= shell + side;
        end
    end

    assign valid    = out_valid_reg;
    assign row      = row_reg;
    assign column   = column_reg;
    assign in_range = in_range_reg;

`ifndef SYNTH
    // Out-of-range words carry zero coordinates
    a_zero_when_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !in_range_reg |-> row_reg == '0 && column_reg == '0)
        else $error("out-of-range word with nonzero coordinates");

    // In-range coordinates lie inside the grid
    a_inside_grid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && in_range_reg |->
            row_reg != '0 && row_reg <= n_b_reg &&
            column_reg != '0 && column_reg <= n_b_reg)
        else $error("coordinates outside the grid");

    // The cell sits on a side of its own shell
    a_on_shell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && in_range_reg |->
            row_reg == shell_b_reg || column_reg == shell_b_reg ||
            row_reg == corner_b_reg || column_reg == corner_b_reg)
        else $error("cell not on the boundary of its shell");
`endif

endmodule
`default_nettype wire

// ===== sv/spiral_index_to_coordinate_top.sv =====
`default_nettype none
// ============================================================================
// spiral_index_to_coordinate_top: spiral position to row and column
// Maps a 1-based position along a clockwise inward spiral over a square grid
// to the 1-based row and column of that cell.
// ============================================================================
//
//   channel  dir  handshake      payload
//   -------  ---  -------------  ---------------------------------------
//   req      in   valid / ready  index
//   rsp      out  valid / ready  row, column, in_range
//   cfg      in   cfg_we         cfg_wdata -> grid_size
//
// The path has one range check stage, a chain of COORD_WIDTH - 1 search
// cells that each settle one bit of the shell count, and two placement
// stages. A new word enters every cycle unless a result word waits on rsp;
// then the whole chain holds in place and req.ready drops. Reset sets
// grid_size to 1 and empties the chain.
//
module spiral_index_to_coordinate_top #(
    parameter int COORD_WIDTH = sic_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [COORD_WIDTH-1:0] cfg_wdata,
    sic_in_if.sink                      req,
    sic_out_if.source                   rsp
);
    import sic_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int XW = COORD_WIDTH - 1;
    localparam int PW = prod_width(COORD_WIDTH);

    logic [W-1:0]   grid_size_reg;
    logic           advance;
    logic [2*W-1:0] area;
    logic           in_range_next;
    ctl_t           ctl0_next;

    ctl_t                   ctl0_reg;
    logic [W-1:0]           n0_reg;
    logic [INDEX_WIDTH-1:0] index0_reg;

    ctl_t                   ctl_s   [0:XW];
    logic [W-1:0]           n_s     [0:XW];
    logic [INDEX_WIDTH-1:0] index_s [0:XW];
    logic [XW-1:0]          x_s     [0:XW];

    logic         out_valid;
    logic [W-1:0] out_row;
    logic [W-1:0] out_column;
    logic         out_in_range;

    // Grid size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= W'(GRID_SIZE_RESET);
        end
        else if (cfg_we)
        begin
            grid_size_reg <= cfg_wdata;
        end
    end

    // Advance the chain unless a result word waits
    assign advance   = !out_valid || rsp.ready;
    assign req.ready = advance;

    // Range check: 1 <= index <= n*n
    assign area          = {{W{1'b0}}, grid_size_reg} * {{W{1'b0}}, grid_size_reg};
    assign in_range_next = (req.index != '0) && (PW'(req.index) <= PW'(area));

    always_comb
    begin
        ctl0_next.valid    = req.valid;
        ctl0_next.in_range = req.valid && in_range_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (advance)
        begin
            ctl0_reg <= ctl0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n0_reg     <= grid_size_reg;
            index0_reg <= req.index;
        end
    end

    assign ctl_s[0]   = ctl0_reg;
    assign n_s[0]     = n0_reg;
    assign index_s[0] = index0_reg;
    assign x_s[0]     = '0;

    // Search chain, most significant bit first
    for (genvar i = 0; i < XW; i++)
    begin : g_cell
        sic_search_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .BIT_POS     (XW - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .ctl_in    (ctl_s[i]),
            .n_in      (n_s[i]),
            .index_in  (index_s[i]),
            .x_in      (x_s[i]),
            .ctl_out   (ctl_s[i+1]),
            .n_out     (n_s[i+1]),
            .index_out (index_s[i+1]),
            .x_out     (x_s[i+1])
        );
    end

    // Placement on the shell and result word
    sic_place #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_place (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .ctl_in   (ctl_s[XW]),
        .n_in     (n_s[XW]),
        .index_in (index_s[XW]),
        .x_in     (x_s[XW]),
        .valid    (out_valid),
        .row      (out_row),
        .column   (out_column),
        .in_range (out_in_range)
    );

    assign rsp.valid    = out_valid;
    assign rsp.row      = out_row;
    assign rsp.column   = out_column;
    assign rsp.in_range = out_in_range;

endmodule
`default_nettype wire
